### hw/rtl/rma_pkg.sv
// ----------------------------------------------------------------------------
// rma_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// ring moving average block.
// ----------------------------------------------------------------------------
package rma_pkg;

	localparam int unsigned SAMPLE_W       = 16;
	localparam int unsigned WIN_W          = 5;
	// Largest window is 31 samples of 16 bits, so 21 bits hold any sum.
	localparam int unsigned SUM_W          = SAMPLE_W + WIN_W;
	localparam int unsigned MAG_W          = SUM_W - 1;
	localparam int unsigned DIV_STEPS      = MAG_W;
	localparam int unsigned STEP_W         = $clog2(DIV_STEPS);
	localparam int unsigned RING_DEPTH_DEF = 16;
	localparam int unsigned WIN_RESET      = 16;
	localparam int unsigned OUT_W          = ((SAMPLE_W + WIN_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} rma_state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic div_step;
		logic out_load;
	} rma_cmd_t;

	typedef struct packed {
		logic out_busy;
	} rma_stat_t;

endpackage

### hw/rtl/ring_moving_average_core.sv
// ----------------------------------------------------------------------------
// ring_moving_average_core: a new sample is taken only once the last average is loaded;
// output stalls delay that load. Restoring divider: one quotient bit per cycle, 20 bits.
// Reset sets the window to 16 and empties sum and fill count; no ring clearing pass.
// ----------------------------------------------------------------------------
module ring_moving_average_core #(
	parameter int unsigned RING_DEPTH = rma_pkg::RING_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rma_pkg::WIN_W-1:0]    cfg_wdata,  // window_size
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rma_pkg::SAMPLE_W-1:0] s_tdata,    // [15:0] sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rma_pkg::OUT_W-1:0]    m_tdata     // [15:0] average, [20:16] filled
);

	import rma_pkg::*;

	rma_cmd_t  cmd;
	rma_stat_t stat;

	rma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	rma_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### hw/rtl/rma_ram.sv
// ----------------------------------------------------------------------------
// rma_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rma_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/rma_ctrl.sv
// ----------------------------------------------------------------------------
// rma_ctrl
// Sequencer for one sample: ring read, sum update, bit-serial divide and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module rma_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output rma_pkg::rma_cmd_t  cmd,
	input  rma_pkg::rma_stat_t stat
);

	import rma_pkg::*;

	rma_state_t        state_q;
	rma_state_t        state_d;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				step_d     = '0;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> (state_q == ST_DIV && step_q == '0))
		else $error("divide did not start from step zero");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == STEP_W'(DIV_STEPS - 1)) |=> (state_q == ST_DONE))
		else $error("divide did not finish after its last step");
	a_cmd_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.update, cmd.div_step, cmd.out_load}))
		else $error("more than one datapath command in a cycle");
`endif

endmodule

### hw/rtl/rma_dp.sv
// ----------------------------------------------------------------------------
// rma_dp
// Datapath: window register, ring storage, running sum, fill count,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module rma_dp #(
	parameter int unsigned RING_DEPTH = rma_pkg::RING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rma_pkg::WIN_W-1:0]     cfg_wdata,
	input  logic [rma_pkg::SAMPLE_W-1:0]  s_tdata,
	input  rma_pkg::rma_cmd_t             cmd,
	output rma_pkg::rma_stat_t            stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rma_pkg::OUT_W-1:0]     m_tdata
);

	import rma_pkg::*;

	localparam int unsigned ADDR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned DEPTH_CAP = (RING_DEPTH < 31) ? RING_DEPTH : 31;
	localparam int unsigned PW        = ((ADDR_W > WIN_W) ? ADDR_W : WIN_W) + 1;

	logic [WIN_W-1:0]    win_q;
	logic [WIN_W-1:0]    eff;
	logic [ADDR_W-1:0]   pos_q;
	logic [WIN_W-1:0]    fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] rd_data;
	logic                full;
	logic [PW-1:0]       pos_inc;
	logic signed [SAMPLE_W-1:0] old_s;
	logic signed [SAMPLE_W-1:0] new_s;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [SUM_W-1:0] sum_abs;

	// Divider state: dvd_q shifts the magnitude out and the quotient in.
	logic [MAG_W-1:0]    dvd_q;
	logic [WIN_W-1:0]    rem_q;
	logic                neg_q;
	logic [WIN_W:0]      trial;
	logic [WIN_W:0]      trial_sub;
	logic                ge;
	logic [SAMPLE_W-1:0] quo;
	logic [SAMPLE_W-1:0] avg_next;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [WIN_W-1:0]    filled_q;

	always_comb begin
		if (win_q == '0) begin
			eff = WIN_W'(1);
		end else if (win_q > WIN_W'(DEPTH_CAP)) begin
			eff = WIN_W'(DEPTH_CAP);
		end else begin
			eff = win_q;
		end
	end

	// Entries at or past the fill count were not written since the last
	// clear, so they count as zero until full, without any ring clearing pass.
	assign full    = (fill_q == eff);
	assign pos_inc = PW'(pos_q) + 1'b1;
	assign old_s   = full ? $signed(rd_data) : '0;
	assign new_s   = $signed(sample_q);
	assign sum_new = sum_q - SUM_W'(old_s) + SUM_W'(new_s);
	assign sum_abs = sum_new[SUM_W-1] ? -sum_new : sum_new;

	rma_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (cmd.accept),
		.raddr (pos_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= WIN_W'(WIN_RESET);
			pos_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cfg_we) begin
			win_q  <= cfg_wdata;
			pos_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_new;
			pos_q <= (pos_inc == PW'(eff)) ? '0 : pos_inc[ADDR_W-1:0];
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign trial     = {rem_q, dvd_q[MAG_W-1]};
	assign ge        = (trial >= {1'b0, fill_q});
	assign trial_sub = trial - {1'b0, fill_q};
	assign quo       = dvd_q[SAMPLE_W-1:0];
	assign avg_next  = neg_q ? (~quo + 1'b1) : quo;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= s_tdata;
		end
		if (cmd.update) begin
			dvd_q <= sum_abs[MAG_W-1:0];
			rem_q <= '0;
			neg_q <= sum_new[SUM_W-1];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[MAG_W-2:0], ge};
			rem_q <= ge ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];
		end
		if (cmd.out_load) begin
			avg_q    <= avg_next;
			filled_q <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_busy = out_valid_q && !m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = OUT_W'({filled_q, avg_q});

`ifndef ASSERT_OFF
	a_fill_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= eff)
		else $error("fill count exceeds the effective window");
	a_pos_lt_win: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(pos_q) < PW'(eff))
		else $error("write position outside the effective window");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !m_tready))
		else $error("output register overwritten while still held");
`endif

endmodule

### dv/tb_ring_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_moving_average_core
// Drives signed samples into the moving average core under several window
// settings. A local copy of the ring, sum and fill count predicts each
// average, and every returned item is checked against it in order.
// ----------------------------------------------------------------------------
module tb_ring_moving_average_core;

	import rma_pkg::*;

	localparam int DEPTH         = RING_DEPTH_DEF;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic [WIN_W-1:0]           filled;
	} avg_result_t;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_PERIODIC,
		RX_RARE
	} rx_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [WIN_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	// Predictor state for the window.
	logic [WIN_W-1:0]           window_setting = WIN_W'(WIN_RESET);
	logic signed [SAMPLE_W-1:0] hist[DEPTH];
	int                         hist_pos   = 0;
	int                         hist_count = 0;
	int                         hist_sum   = 0;
	avg_result_t                avg_expect_q[$];
	avg_result_t                want;

	int       fail_count   = 0;
	int       burst_left   = 0;
	int       hold_request = 0;
	int       hold_left    = 0;
	rx_mode_t rx_mode      = RX_FREE;
	int       rx_mode_left = 0;
	int       rx_phase     = 0;

	ring_moving_average_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("ring_moving_average_core verification failed");
		$finish;
	end

	task automatic clear_history();
		for (int i = 0; i < DEPTH; i++) begin
			hist[i] = '0;
		end
		hist_pos   = 0;
		hist_count = 0;
		hist_sum   = 0;
	endtask

	// Updates the predicted window with one accepted sample and queues the average.
	task automatic advance_window(input logic [SAMPLE_W-1:0] raw);
		int          span;
		avg_result_t r;
		if (window_setting == 0) begin
			span = 1;
		end else if (window_setting > DEPTH) begin
			span = DEPTH;
		end else begin
			span = window_setting;
		end
		if (hist_pos >= span) begin
			hist_pos = 0;
		end
		hist_sum = hist_sum - hist[hist_pos] + $signed(raw);
		hist[hist_pos] = raw;
		hist_pos = (hist_pos + 1 >= span) ? 0 : hist_pos + 1;
		if (hist_count < span) begin
			hist_count++;
		end
		r.average = SAMPLE_W'(hist_sum / hist_count);
		r.filled  = WIN_W'(hist_count);
		avg_expect_q.push_back(r);
	endtask

	// The sender offers items in bursts of random length separated by random gaps.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata  = value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_window(value);
	endtask

	task automatic wait_for_results();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid   = 1'b0;
		burst_left = 0;
		while (avg_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (avg_expect_q.size() != 0) begin
			$error("%0d expected averages never arrived", avg_expect_q.size());
			fail_count++;
			avg_expect_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A window write restarts averaging, so the predictor is cleared with it.
	task automatic write_window(input logic [WIN_W-1:0] setting);
		wait_for_results();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = setting;
		@(negedge clk);
		cfg_we = 1'b0;
		window_setting = setting;
		clear_history();
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_W'($urandom_range(0, 16) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic test_reset_window_extremes();
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h8000);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		send_sample(16'hFFFE);
	endtask

	// A window of zero behaves as a window of one.
	task automatic test_window_of_zero();
		write_window('0);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'hFFFF);
	endtask

	task automatic test_short_window_wrap();
		write_window(5'd2);
		send_sample(16'h0007);
		send_sample(16'hFFFD);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0003);
	endtask

	// Settings above the ring depth are clamped to it.
	task automatic test_window_above_depth();
		write_window('1);
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0005);
	endtask

	task automatic test_backpressure();
		write_window(5'd4);
		hold_request = HOLD_CYCLES;
		burst_left   = 16;
		for (int i = 0; i < 12; i++) begin
			send_sample(random_sample());
		end
		wait_for_results();
	endtask

	task automatic test_random_phases();
		logic [WIN_W-1:0]    setting;
		logic [SAMPLE_W-1:0] extreme;
		int                  count;
		int                  run;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: setting = 5'd16;
				1: setting = 5'd1;
				2: setting = 5'd15;
				3: setting = 5'd17;
				4: setting = 5'd3;
				default: setting = WIN_W'($urandom_range(0, 31));
			endcase
			write_window(setting);
			count = $urandom_range(60, 110);
			while (count > 0) begin
				// Runs of one extreme drive the sum to its limits whenever a run covers a full window.
				if ($urandom_range(0, 19) == 0) begin
					extreme = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					run = $urandom_range(8, 20);
					for (int i = 0; i < run; i++) begin
						send_sample(extreme);
					end
					count -= run;
				end else begin
					send_sample(random_sample());
					count--;
				end
			end
		end
	endtask

	// The receiver stalls on its own pattern, with a long hold-off when a test requests one.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(40, 200);
			end
			rx_mode_left--;
			rx_phase++;
			case (rx_mode)
				RX_FREE:     m_tready = 1'b1;
				RX_COIN:     m_tready = 1'($urandom_range(0, 1));
				RX_PERIODIC: m_tready = (rx_phase % 7) >= 3;
				default:     m_tready = ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (avg_expect_q.size() == 0) begin
				$error("unexpected item: average %0d filled %0d",
					$signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W+WIN_W-1:SAMPLE_W]);
				fail_count++;
			end else begin
				want = avg_expect_q.pop_front();
				if (m_tdata[SAMPLE_W-1:0] !== want.average) begin
					$error("average: expected %0d, got %0d",
						want.average, $signed(m_tdata[SAMPLE_W-1:0]));
					fail_count++;
				end
				if (m_tdata[SAMPLE_W+WIN_W-1:SAMPLE_W] !== want.filled) begin
					$error("filled: expected %0d, got %0d",
						want.filled, m_tdata[SAMPLE_W+WIN_W-1:SAMPLE_W]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		clear_history();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_window_extremes();
		test_window_of_zero();
		test_short_window_wrap();
		test_window_above_depth();
		test_backpressure();
		test_random_phases();
		wait_for_results();

		if (fail_count == 0) begin
			$display("ring_moving_average_core verification clean");
		end else begin
			$display("ring_moving_average_core verification failed");
		end
		$finish;
	end

endmodule
